// ===== hw/rtl/pfe_pkg.sv =====
// pfe_pkg: shared sizes, operator and error codes for the postfix evaluator
// no dependencies; compiled first

package pfe_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int VALUE_WIDTH = 32;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W  = $clog2(VALUE_WIDTH);

    // fixed widths of the token and result words
    localparam int OPERAND_W = 32;
    localparam int RESULT_W  = 32;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DIVZERO   = 2'd3
    } err_t;

    typedef enum logic {
        KIND_OPERAND  = 1'b0,
        KIND_OPERATOR = 1'b1
    } kind_t;

    // first error of an expression wins
    function automatic err_t note_error(err_t cur, err_t code);
        return (cur == ERR_OK) ? code : cur;
    endfunction

endpackage

// ===== hw/rtl/pfe_if.sv =====
// pfe_token_if / pfe_result_if: valid/ready channels for tokens and results
// depends on pfe_pkg

interface pfe_token_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic signed [pfe_pkg::OPERAND_W-1:0] operand_value;
    logic [1:0]                       operator_code;
    logic                             last_token;

    modport source (output valid, kind, operand_value, operator_code, last_token,
                    input ready);
    modport sink   (input valid, kind, operand_value, operator_code, last_token,
                    output ready);
endinterface

interface pfe_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [pfe_pkg::RESULT_W-1:0] result_value;
    logic [1:0]                          error_code;

    modport source (output valid, result_value, error_code, input ready);
    modport sink   (input valid, result_value, error_code, output ready);
endinterface

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// postfix_expression_evaluator: postfix token evaluator over a value stack in RAM
// depends on pfe_pkg and the channel interfaces in pfe_if.sv
//
// Usage:
//   tokens enter on the tok channel (valid/ready). An operand word pushes its
//   value; an operator word pops right then left and pushes the result. On a
//   word with last_token set, one word leaves on the res channel: the top of
//   the stack (0 if empty) and the first error of the expression, after which
//   the stack and the error are cleared.
// Sequence:
//   an operand is pushed as it is taken; an add/sub/mul reads the left operand
//   from the stack RAM through a registered read, then writes the result back;
//   a divide runs the one-bit-a-cycle divider (S_DIV) and writes back in S_DIVW.
//   a last token then passes S_DONE, which loads the output register.
//   one token is in work at a time; tok.ready is high while the block waits
//   for a token.
// Reset: stack empty, no error, no result pending. RAM contents are not
//   cleared; only written entries are ever read.
// Stall: the result sits in an output register; further tokens are taken
//   while it waits, and the block holds before the next result until it is taken.

module postfix_expression_evaluator (
    input  logic           clk,
    input  logic           rst_n,
    pfe_token_if.sink      tok,
    pfe_result_if.source   res
);
    import pfe_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CALC = 6'b000010,
        S_DIV  = 6'b000100,
        S_DIVW = 6'b001000,
        S_DONE = 6'b010000,
        S_HOLD = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    err_t err_reg, err_next;
    value_t top_reg, top_next;
    op_t op_reg, op_next;
    logic last_reg, last_next;

    // divider
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic signed [RESULT_W-1:0]   out_value_reg, out_value_next;
    err_t                         out_err_reg, out_err_next;

    // stack memory
    value_t mem [STACK_DEPTH];
    value_t rd_data_reg;
    logic   wr_en;
    logic [ADDR_W-1:0] wr_addr;
    value_t wr_data;
    logic [SP_W-1:0] sp_minus2;
    logic [ADDR_W-1:0] rd_addr;

    logic accept;
    value_t left, right, push_val;
    logic [VALUE_WIDTH-1:0] left_mag, right_mag;
    logic [VALUE_WIDTH:0] rem_sh, diff;
    logic out_free;

    assign accept    = tok.valid && tok.ready;
    assign tok.ready = (state_reg == S_IDLE);
    assign sp_minus2 = sp_reg - SP_W'(2);
    assign rd_addr   = sp_minus2[ADDR_W-1:0];
    assign out_free  = !out_valid_reg || res.ready;

    assign left      = rd_data_reg;
    assign right     = top_reg;
    assign push_val  = VALUE_WIDTH'(tok.operand_value);
    assign left_mag  = left[VALUE_WIDTH-1] ? -left : left;
    assign right_mag = right[VALUE_WIDTH-1] ? -right : right;

    // one restoring step
    assign rem_sh = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};

    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.error_code   = out_err_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // left operand sits at sp-2 when an operator is taken
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dsr_next       = dsr_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        wr_en          = 1'b0;
        wr_addr        = sp_reg[ADDR_W-1:0];
        wr_data        = push_val;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op_t'(tok.operator_code);
                    last_next = tok.last_token;
                    state_next = tok.last_token ? S_DONE : S_IDLE;
                    if (kind_t'(tok.kind) == KIND_OPERAND)
                    begin
                        if (sp_reg == SP_W'(STACK_DEPTH))
                        begin
                            err_next = note_error(err_reg, ERR_OVERFLOW);
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            top_next = push_val;
                            sp_next  = sp_reg + SP_W'(1);
                        end
                    end
                    else if (sp_reg < SP_W'(2))
                    begin
                        err_next = note_error(err_reg, ERR_UNDERFLOW);
                    end
                    else
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                wr_addr = rd_addr;
                if (op_reg == OP_DIV && right != '0)
                begin
                    rem_next   = '0;
                    quo_next   = left_mag;
                    dsr_next   = right_mag;
                    neg_next   = left[VALUE_WIDTH-1] ^ right[VALUE_WIDTH-1];
                    cnt_next   = CNT_W'(VALUE_WIDTH - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    unique case (op_reg)
                        OP_ADD: wr_data = left + right;
                        OP_SUB: wr_data = left - right;
                        OP_MUL: wr_data = left * right;
                        OP_DIV:
                        begin
                            wr_data  = '0;
                            err_next = note_error(err_reg, ERR_DIVZERO);
                        end
                        default: wr_data = '0;
                    endcase
                    wr_en      = 1'b1;
                    top_next   = wr_data;
                    sp_next    = sp_reg - SP_W'(1);
                    state_next = last_reg ? S_DONE : S_IDLE;
                end
            end
            S_DIV:
            begin
                if (!diff[VALUE_WIDTH])
                begin
                    rem_next = diff[VALUE_WIDTH-1:0];
                    quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[VALUE_WIDTH-1:0];
                    quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                wr_addr    = rd_addr;
                wr_data    = neg_reg ? -quo_reg : quo_reg;
                wr_en      = 1'b1;
                top_next   = wr_data;
                sp_next    = sp_reg - SP_W'(1);
                state_next = last_reg ? S_DONE : S_IDLE;
            end
            S_DONE, S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = (sp_reg == '0) ? '0 : RESULT_W'(top_reg);
                    out_err_next   = err_reg;
                    sp_next        = '0;
                    err_next       = ERR_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ERR_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        op_reg        <= op_next;
        last_reg      <= last_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        dsr_reg       <= dsr_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

endmodule
